[src/sxd_pkg.sv]
// Package for the STX/ETX deframer with XOR block check.
// Holds the framing bytes, the receive phase type and the result kind codes.
// No dependencies.
package sxd_pkg;

	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_SID  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_BCC  = 3'd4,
		PH_ETX  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_PAYLOAD = 3'd1,
		KIND_OK      = 3'd2,
		KIND_BADBCC  = 3'd3,
		KIND_BADETX  = 3'd4
	} kind_t;

endpackage

[src/stx_etx_xor_bcc_deframer.sv]
// Top level of the STX/ETX deframer with XOR block check.
// Depends on sxd_pkg for the phase type, kind codes and framing bytes.
//
// Usage: received serial bytes enter on rx_byte with in_valid/in_stall. The
// block hunts for STX, takes station id and length, reports a header beat,
// reports each payload beat, checks the XOR BCC and the closing ETX, and
// reports a status beat (frame ok, bad bcc or bad etx) with last set.
// Downstream drops the beats of a frame that ends in an error.
// Results leave on kind, data_byte, station_id, frame_length and last with
// out_valid/out_stall. Every beat carries the current station id and length.
// Throughput is one input beat per cycle while in_stall is low. An accepted
// byte is held in the input register and decoded from there into the output
// register, where its result waits until the receiver takes it. Bytes that
// cause no result pass through without waiting for the output side.
// While the receiver stalls a full output register, a byte that would give
// a result waits in the input register and in_stall rises; no beat is lost.
// Reset clears the valid flags and returns the block to STX hunting with a
// cleared check accumulator, count, station id and length.
module stx_etx_xor_bcc_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] station_id,
	output logic [7:0] frame_length,
	output logic       last
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               valid_s2;
	sxd_pkg::kind_t     kind_s2;
	logic [7:0]         data_s2;
	logic [7:0]         station_s2;
	logic [7:0]         length_s2;
	logic               last_s2;

	sxd_pkg::phase_t    phase_q;
	logic [7:0]         accum_q;
	logic [7:0]         left_q;
	logic [7:0]         station_q;
	logic [7:0]         length_q;

	sxd_pkg::phase_t    phase_d;
	logic [7:0]         accum_d;
	logic [7:0]         left_d;
	logic [7:0]         station_d;
	logic [7:0]         length_d;
	logic               res_valid;
	sxd_pkg::kind_t     res_kind;
	logic [7:0]         res_data;
	logic               res_last;

	logic               s2_free;
	logic               s1_adv;
	logic               s1_take;

	always_comb begin
		phase_d   = phase_q;
		accum_d   = accum_q;
		left_d    = left_q;
		station_d = station_q;
		length_d  = length_q;
		res_valid = 1'b0;
		res_kind  = sxd_pkg::KIND_HEADER;
		res_data  = 8'h00;
		res_last  = 1'b0;
		unique case (phase_q)
			sxd_pkg::PH_SID: begin
				station_d = byte_s1;
				accum_d   = accum_q ^ byte_s1;
				phase_d   = sxd_pkg::PH_LEN;
			end
			sxd_pkg::PH_LEN: begin
				length_d  = byte_s1;
				left_d    = byte_s1;
				accum_d   = accum_q ^ byte_s1;
				phase_d   = (byte_s1 != 8'h00) ? sxd_pkg::PH_DATA : sxd_pkg::PH_BCC;
				res_valid = 1'b1;
				res_kind  = sxd_pkg::KIND_HEADER;
			end
			sxd_pkg::PH_DATA: begin
				accum_d   = accum_q ^ byte_s1;
				left_d    = left_q - 8'd1;
				if (left_q == 8'd1) begin
					phase_d = sxd_pkg::PH_BCC;
				end
				res_valid = 1'b1;
				res_kind  = sxd_pkg::KIND_PAYLOAD;
				res_data  = byte_s1;
			end
			sxd_pkg::PH_BCC: begin
				if (byte_s1 != accum_q) begin
					phase_d   = sxd_pkg::PH_HUNT;
					res_valid = 1'b1;
					res_kind  = sxd_pkg::KIND_BADBCC;
					res_last  = 1'b1;
				end else begin
					phase_d = sxd_pkg::PH_ETX;
				end
			end
			sxd_pkg::PH_ETX: begin
				phase_d   = sxd_pkg::PH_HUNT;
				res_valid = 1'b1;
				res_last  = 1'b1;
				res_kind  = (byte_s1 == sxd_pkg::ETX_BYTE) ? sxd_pkg::KIND_OK
				                                           : sxd_pkg::KIND_BADETX;
			end
			default: begin
				phase_d = sxd_pkg::PH_HUNT;
				if (byte_s1 == sxd_pkg::STX_BYTE) begin
					accum_d = 8'h00;
					phase_d = sxd_pkg::PH_SID;
				end
			end
		endcase
	end

	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_adv   = valid_s1 && (!res_valid || s2_free);
	assign in_stall = valid_s1 && !s1_adv;
	assign s1_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sxd_pkg::PH_HUNT;
			accum_q   <= 8'h00;
			left_q    <= 8'h00;
			station_q <= 8'h00;
			length_q  <= 8'h00;
		end else if (s1_adv) begin
			phase_q   <= phase_d;
			accum_q   <= accum_d;
			left_q    <= left_d;
			station_q <= station_d;
			length_q  <= length_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && res_valid) begin
			kind_s2    <= res_kind;
			data_s2    <= res_data;
			station_s2 <= station_d;
			length_s2  <= length_d;
			last_s2    <= res_last;
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = kind_s2;
	assign data_byte    = data_s2;
	assign station_id   = station_s2;
	assign frame_length = length_s2;
	assign last         = last_s2;

`ifndef ASSERT_OFF
	a_last_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == ((kind == sxd_pkg::KIND_OK) ||
			(kind == sxd_pkg::KIND_BADBCC) || (kind == sxd_pkg::KIND_BADETX))))
		else $error("last does not match a status beat");

	a_data_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind != sxd_pkg::KIND_PAYLOAD)) |-> (data_byte == 8'h00))
		else $error("data_byte set on a non-payload beat");

	a_no_stall_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with an empty input register");

	a_status_returns_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && res_valid && res_last) |=> (phase_q == sxd_pkg::PH_HUNT))
		else $error("phase did not return to hunting after a frame end");
`endif

endmodule
